>>> design/tcp_segment_sorted_table_assert.svh
// assertion macros for the sorted segment table
// expects clk and rst_n in the scope of each use
`ifndef TCP_SEGMENT_SORTED_TABLE_ASSERT_SVH
`define TCP_SEGMENT_SORTED_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSST_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TSST_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define TSST_ASSERT(label, cond, msg)
`define TSST_ASSERT_NEXT(label, trig, cond, msg)
`endif
`endif

>>> design/tsst_pkg.sv
// types and constants of the sorted segment table
// no dependencies
package tsst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic       FUNC_ADD = 1'b0;
    localparam logic       FUNC_GET = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EMPTY       = 2'd1;
    localparam logic [1:0] ST_ACK_BEYOND  = 2'd2;
    localparam logic [1:0] ST_FULL        = 2'd3;

    typedef struct packed {
        logic        func;
        logic [31:0] seg_seq;
        logic [15:0] payload_len;
        logic [15:0] buf_tag;
        logic [31:0] ack_number;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        replaced;
        logic [15:0] out_tag;
        logic [31:0] out_seq;
        logic [31:0] out_seq_end;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] seq_end;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
        logic update;
    } cell_cmd_t;

    typedef struct packed {
        logic occ;
        logic lt;
        logic eq;
        logic ge;
    } cell_flags_t;

endpackage

>>> design/tsst_cell.sv
// one slot of the sorted table: stored entry, compare flags, shift muxing
// depends on tsst_pkg
module tsst_cell
    import tsst_pkg::*;
(
    input  logic        clk,
    input  logic        cap,
    input  logic        occ,
    input  logic [31:0] key_seq,
    input  logic [31:0] key_ack,
    input  cell_cmd_t   cmd,
    input  entry_t      new_entry,
    input  entry_t      left,
    input  entry_t      right,
    output entry_t      entry,
    output cell_flags_t flags
);

    entry_t      entry_reg;
    entry_t      entry_next;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;

    always_comb
    begin
        flags_next.occ = occ;
        flags_next.lt  = occ && (entry_reg.start < key_seq);
        flags_next.eq  = occ && (entry_reg.start == key_seq);
        flags_next.ge  = occ && (entry_reg.seq_end >= key_ack);
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.load_new)
        begin
            entry_next = new_entry;
        end
        else if (cmd.take_left)
        begin
            entry_next = left;
        end
        else if (cmd.take_right)
        begin
            entry_next = right;
        end
        else if (cmd.update)
        begin
            entry_next.seq_end = new_entry.seq_end;
            entry_next.tag     = new_entry.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cap)
        begin
            flags_reg <= flags_next;
        end
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

>>> design/tcp_segment_sorted_table.sv
// sorted tcp segment table, top level: handshakes, sequencing, cell row
// depends on tsst_pkg, tsst_cell and tcp_segment_sorted_table_assert.svh
//
// req carries one item: an add (func 0) inserts seg_seq with end
// seg_seq + payload_len and buf_tag in start order, replacing an entry of
// equal start; a get (func 1) removes the first entry whose end is at
// or above ack_number, if the last entry's end is. rsp returns exactly
// one item per req item. an item accepted at one edge has its compare
// flags captured in every cell at that edge; at the next edge the row
// shifts or writes in one step and the result is registered, so rsp_valid
// rises at that edge. no new item is accepted while one is executing.
// req_ready is low in the execute cycle and while a result waits with
// rsp_ready low; a waiting result is held unchanged until taken.
// after reset the table is empty and no result is pending; entries come
// up with no defined contents and are only read once written.
`include "tcp_segment_sorted_table_assert.svh"
module tcp_segment_sorted_table
    import tsst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    typedef enum logic [1:0] {
        IDLE = 2'b01,
        EXEC = 2'b10
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    rsp_item_t   rsp_reg;
    rsp_item_t   rsp_next;
    logic        func_reg;
    entry_t      new_reg;

    logic        accept;
    logic        exec;
    entry_t      entries [TABLE_DEPTH];
    cell_flags_t flags [TABLE_DEPTH];
    cell_cmd_t   cmds [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] seen;
    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] last_ok_vec;
    logic [TABLE_DEPTH-1:0] sel;
    logic        any_eq;
    logic        full;
    logic        empty;
    logic        last_ok;
    logic        do_insert;
    logic        do_update;
    logic        do_remove;
    entry_t      picked;

    assign accept    = req_valid && req_ready;
    assign exec      = (state_reg == EXEC);
    assign req_ready = (state_reg == IDLE) && (!rsp_valid_reg || rsp_ready);

    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign empty = (count_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            entry_t left_in;
            entry_t right_in;

            if (gi == 0)
            begin : g_first
                assign left_in = '0;
                assign seen[gi] = flags[gi].ge;
                assign hit[gi]  = flags[gi].ge;
                assign cmds[gi].load_new  = do_insert && !flags[gi].lt;
                assign cmds[gi].take_left = 1'b0;
            end
            else
            begin : g_rest
                assign left_in = entries[gi-1];
                assign seen[gi] = seen[gi-1] || flags[gi].ge;
                assign hit[gi]  = flags[gi].ge && !seen[gi-1];
                assign cmds[gi].load_new  = do_insert && flags[gi-1].lt && !flags[gi].lt;
                assign cmds[gi].take_left = do_insert && flags[gi-1].occ && !flags[gi-1].lt;
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign right_in = '0;
                assign last_ok_vec[gi] = flags[gi].occ && flags[gi].ge;
            end
            else
            begin : g_mid
                assign right_in = entries[gi+1];
                assign last_ok_vec[gi] = flags[gi].occ && !flags[gi+1].occ && flags[gi].ge;
            end

            assign cmds[gi].take_right = do_remove && seen[gi];
            assign cmds[gi].update     = do_update && flags[gi].eq;
            assign eq_vec[gi]          = flags[gi].eq;

            tsst_cell u_cell (
                .clk       (clk),
                .cap       (accept),
                .occ       (count_reg > CNT_W'(gi)),
                .key_seq   (req.seg_seq),
                .key_ack   (req.ack_number),
                .cmd       (cmds[gi]),
                .new_entry (new_reg),
                .left      (left_in),
                .right     (right_in),
                .entry     (entries[gi]),
                .flags     (flags[gi])
            );
        end
    endgenerate

    assign any_eq    = |eq_vec;
    assign last_ok   = |last_ok_vec;
    assign do_update = exec && (func_reg == FUNC_ADD) && any_eq;
    assign do_insert = exec && (func_reg == FUNC_ADD) && !any_eq && !full;
    assign do_remove = exec && (func_reg == FUNC_GET) && !empty && last_ok;
    assign sel       = do_update ? eq_vec : (do_remove ? hit : '0);

    always_comb
    begin
        picked = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (sel[i])
            begin
                picked = picked | entries[i];
            end
        end
    end

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_next.replaced    = do_update;
        rsp_next.out_tag     = picked.tag;
        rsp_next.out_seq     = picked.start;
        rsp_next.out_seq_end = picked.seq_end;
        if (func_reg == FUNC_ADD)
        begin
            rsp_next.status = (!any_eq && full) ? ST_FULL : ST_OK;
        end
        else if (empty)
        begin
            rsp_next.status = ST_EMPTY;
        end
        else if (!last_ok)
        begin
            rsp_next.status = ST_ACK_BEYOND;
        end
        else
        begin
            rsp_next.status = ST_OK;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:    state_next = accept ? EXEC : IDLE;
            EXEC:    state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (exec)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg        <= req.func;
            new_reg.start   <= req.seg_seq;
            new_reg.seq_end <= req.seg_seq + {16'd0, req.payload_len};
            new_reg.tag     <= req.buf_tag;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TSST_ASSERT(a_count_bound, count_reg <= CNT_W'(TABLE_DEPTH), "entry count above depth")
    `TSST_ASSERT(a_sel_onehot, $onehot0(sel), "more than one entry selected")
    `TSST_ASSERT(a_exec_out_free, !exec || !rsp_valid_reg, "result register busy in execute")
    `TSST_ASSERT_NEXT(a_accept_exec, accept, state_reg == EXEC && rsp_valid_next,
        "accepted item not executed")
    `TSST_ASSERT_NEXT(a_count_step, exec && (func_reg == FUNC_ADD),
        count_reg >= $past(count_reg), "add reduced entry count")

endmodule

>>> test/tb.sv
// self-checking testbench for tcp_segment_sorted_table: directed and random add and get items
// with random idling on both channels, checked against an in-bench sorted segment table
// depends on tsst_pkg and the tcp_segment_sorted_table rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsst_pkg::*;

    localparam int RANDOM_ITEMS   = 1926;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ADD_MIX[6]     = '{85, 30, 60, 95, 10, 50};

    class segment_table_scoreboard;
        entry_t    segments[$];
        rsp_item_t expected[$];
        int        errors;
        int        items;
        int        replacements;
        int        status_seen[4];

        function void note_request(req_item_t it);
            rsp_item_t r;
            entry_t    e;
            int        pos;
            r   = '0;
            pos = 0;
            if (it.func == FUNC_ADD)
            begin
                e.start   = it.seg_seq;
                e.seq_end = it.seg_seq + {16'd0, it.payload_len};
                e.tag     = it.buf_tag;
                while (pos < segments.size() && segments[pos].start < e.start)
                    pos++;
                if (pos < segments.size() && segments[pos].start == e.start)
                begin
                    r.replaced    = 1'b1;
                    r.out_tag     = segments[pos].tag;
                    r.out_seq     = segments[pos].start;
                    r.out_seq_end = segments[pos].seq_end;
                    segments[pos] = e;
                end
                else if (segments.size() >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                    segments.insert(pos, e);
            end
            else if (segments.size() == 0)
                r.status = ST_EMPTY;
            else if (segments[segments.size() - 1].seq_end < it.ack_number)
                r.status = ST_ACK_BEYOND;
            else
            begin
                while (pos < segments.size() - 1 && segments[pos].seq_end < it.ack_number)
                    pos++;
                r.out_tag     = segments[pos].tag;
                r.out_seq     = segments[pos].start;
                r.out_seq_end = segments[pos].seq_end;
                segments.delete(pos);
            end
            items++;
            status_seen[r.status]++;
            replacements += int'(r.replaced);
            expected.push_back(r);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function logic [31:0] some_end();
            if (segments.size() == 0)
                return $urandom;
            return segments[$urandom_range(0, segments.size() - 1)].seq_end;
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t on %s: got %h, expected %h", $realtime, field, got, want);
            errors++;
        endtask

        task check_result(rsp_item_t got);
            rsp_item_t want;
            if (expected.size() == 0)
            begin
                report("result item with none pending", 32'(got.status), '0);
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.replaced !== want.replaced)
                report("replaced", 32'(got.replaced), 32'(want.replaced));
            if (got.out_tag !== want.out_tag)
                report("out_tag", 32'(got.out_tag), 32'(want.out_tag));
            if (got.out_seq !== want.out_seq)
                report("out_seq", got.out_seq, want.out_seq);
            if (got.out_seq_end !== want.out_seq_end)
                report("out_seq_end", got.out_seq_end, want.out_seq_end);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;

    bit        quiet;
    int        stall_cycles;

    segment_table_scoreboard sb = new();

    tcp_segment_sorted_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(negedge clk)
        rsp_ready <= quiet || ($urandom_range(0, 99) >= 8);

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles <= 0;
            else
            begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles == WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    function automatic req_item_t make_add(logic [31:0] seq, logic [15:0] len, logic [15:0] tag);
        req_item_t it;
        it.func        = FUNC_ADD;
        it.seg_seq     = seq;
        it.payload_len = len;
        it.buf_tag     = tag;
        it.ack_number  = $urandom;
        return it;
    endfunction

    function automatic req_item_t make_get(logic [31:0] ack);
        req_item_t it;
        it.func        = FUNC_GET;
        it.seg_seq     = $urandom;
        it.payload_len = 16'($urandom);
        it.buf_tag     = 16'($urandom);
        it.ack_number  = ack;
        return it;
    endfunction

    task send_item(req_item_t it);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 8)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(it);
    endtask

    task wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int          pick;
        int          add_pct;
        logic [31:0] seq;
        logic [31:0] ack;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        rsp_ready    = 1'b0;
        quiet        = 1'b0;
        stall_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, replace, ack past end, full table
        send_item(make_get(32'h0000_0000));
        send_item(make_add(32'h0000_0000, 16'h0000, 16'h0000));
        send_item(make_add(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_add(32'h0000_0000, 16'h8000, 16'h5A5A));
        send_item(make_get(32'hFFFF_FFFF));
        send_item(make_get(32'h0000_0000));
        for (int i = 1; i < TABLE_DEPTH; i++)
            send_item(make_add(32'h1000_0000 * i, 16'(16'h0100 * i), 16'(16'hA500 + i)));
        send_item(make_add(32'h0800_0000, 16'h1234, 16'h0F0F));
        send_item(make_add(32'h1000_0000, 16'h0001, 16'hF0F0));
        send_item(make_get(32'h3000_0200));
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 900 && n < 1200);
            if (n % 250 == 249)
                wait_drained();
            add_pct = ADD_MIX[(n / 150) % 6];
            pick    = $urandom_range(0, 9);
            if ($urandom_range(0, 99) < add_pct)
            begin
                if (pick < 6)
                    seq = 32'h0001_0000 * $urandom_range(0, 23) + $urandom_range(0, 1);
                else if (pick < 8)
                    seq = $urandom;
                else if (pick == 8)
                    seq = 32'hFFFF_FFFF - $urandom_range(0, 70000);
                else
                    seq = $urandom_range(0, 255);
                send_item(make_add(seq, 16'($urandom), 16'($urandom)));
            end
            else
            begin
                if (pick < 4)
                    ack = sb.some_end() + $urandom_range(0, 2) - 1;
                else if (pick == 4)
                    ack = 32'h0000_0000;
                else if (pick == 5)
                    ack = $urandom;
                else if (pick < 8)
                    ack = 32'h0001_0000 * $urandom_range(0, 24);
                else if (pick == 8)
                    ack = 32'hFFFF_FFFF;
                else
                    ack = sb.some_end() + $urandom_range(0, 255);
                send_item(make_get(ack));
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items: %0d completed ok, %0d replacements, %0d adds dropped on a full table",
                 sb.items, sb.status_seen[ST_OK], sb.replacements, sb.status_seen[ST_FULL]);
        $display("gets refused: %0d on an empty table, %0d with ack past the last end",
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_ACK_BEYOND]);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
